// ----- hdl/etcbf_pkg.sv -----
// Shared types, constants, sequence step codes and saturation helpers of the safety filter.
package etcbf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GOAL_TOL  = 3277;
	localparam int MAX_SPEED = 14418;
	localparam int MAX_TURN  = 186122;

	localparam logic signed [67:0] GOAL_TOL2 = 68'sd10738729;
	localparam logic signed [67:0] START_SQ  = 68'sd429025;
	localparam logic signed [67:0] MARGIN_Q  = 68'sd3277;
	localparam logic signed [67:0] DRIFT_Q   = 68'sd6554;
	localparam logic signed [67:0] DRIFT_SQ  = 68'sd42954916;
	localparam logic signed [67:0] TINY_Q    = 68'sd0;

	localparam int DIV_BITS = 48;
	localparam int DEN_W    = 50;
	localparam int STEP_W   = 6;

	// Configuration register indexes.
	localparam logic [2:0] REG_GOAL_X  = 3'd0;
	localparam logic [2:0] REG_GOAL_Y  = 3'd1;
	localparam logic [2:0] REG_OBST_X  = 3'd2;
	localparam logic [2:0] REG_OBST_Y  = 3'd3;
	localparam logic [2:0] REG_SAFE_R  = 3'd4;
	localparam logic [2:0] REG_LOOK    = 3'd5;
	localparam logic [2:0] REG_KP      = 3'd6;
	localparam logic [2:0] REG_EPS     = 3'd7;

	// Trigger kinds.
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_BARRIER = 2'd1;
	localparam logic [1:0] KIND_RECOV   = 2'd2;
	localparam logic [1:0] KIND_START   = 2'd3;

	// Sequencer steps.
	localparam logic [5:0] SQ_00 = 6'd0;
	localparam logic [5:0] SQ_01 = 6'd1;
	localparam logic [5:0] SQ_02 = 6'd2;
	localparam logic [5:0] SQ_03 = 6'd3;
	localparam logic [5:0] SQ_04 = 6'd4;
	localparam logic [5:0] SQ_05 = 6'd5;
	localparam logic [5:0] SQ_06 = 6'd6;
	localparam logic [5:0] SQ_07 = 6'd7;
	localparam logic [5:0] SQ_08 = 6'd8;
	localparam logic [5:0] SQ_09 = 6'd9;
	localparam logic [5:0] SQ_10 = 6'd10;
	localparam logic [5:0] SQ_11 = 6'd11;
	localparam logic [5:0] SQ_12 = 6'd12;
	localparam logic [5:0] SQ_13 = 6'd13;
	localparam logic [5:0] SQ_14 = 6'd14;
	localparam logic [5:0] SQ_15 = 6'd15;
	localparam logic [5:0] SQ_16 = 6'd16;
	localparam logic [5:0] SQ_17 = 6'd17;
	localparam logic [5:0] SQ_18 = 6'd18;
	localparam logic [5:0] SQ_19 = 6'd19;
	localparam logic [5:0] SQ_20 = 6'd20;
	localparam logic [5:0] SQ_21 = 6'd21;
	localparam logic [5:0] SQ_22 = 6'd22;
	localparam logic [5:0] SQ_23 = 6'd23;
	localparam logic [5:0] SQ_24 = 6'd24;
	localparam logic [5:0] SQ_25 = 6'd25;
	localparam logic [5:0] SQ_26 = 6'd26;
	localparam logic [5:0] SQ_27 = 6'd27;
	localparam logic [5:0] SQ_28 = 6'd28;
	localparam logic [5:0] SQ_29 = 6'd29;
	localparam logic [5:0] SQ_30 = 6'd30;
	localparam logic [5:0] SQ_31 = 6'd31;
	localparam logic [5:0] SQ_32 = 6'd32;
	localparam logic [5:0] SQ_33 = 6'd33;
	localparam logic [5:0] SQ_34 = 6'd34;
	localparam logic [5:0] SQ_35 = 6'd35;
	localparam logic [5:0] SQ_36 = 6'd36;
	localparam logic [5:0] SQ_37 = 6'd37;
	localparam logic [5:0] SQ_38 = 6'd38;
	localparam logic [5:0] SQ_39 = 6'd39;
	localparam logic [5:0] SQ_40 = 6'd40;
	localparam logic [5:0] SQ_41 = 6'd41;
	localparam logic [5:0] SQ_42 = 6'd42;
	localparam logic [5:0] SQ_43 = 6'd43;
	localparam logic [5:0] SQ_44 = 6'd44;

	typedef struct packed {
		logic             run;
		logic [STEP_W-1:0] step;
		logic             load;
		logic             div_go;
		logic             commit;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic reach;
		logic fire;
		logic nd_pos;
		logic tiny;
		logic trig;
		logic div_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
			input logic signed [31:0] lim);
		logic signed [31:0] r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic signed [67:0] absw(input logic signed [67:0] v);
		return (v < 68'sd0) ? -v : v;
	endfunction

endpackage

// ----- hdl/etcbf_div.sv -----
// Iterative restoring divider: sat32((num << FRAC_BITS) / den), truncated toward zero.
module etcbf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [31:0]           num,
	input  logic [etcbf_pkg::DEN_W-1:0]  den,
	output logic                         done,
	output logic signed [31:0]           quo
);
	import etcbf_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [DIV_BITS-1:0] sh_q;
	logic                neg_q;
	logic [DEN_W:0]      trial;
	logic                fits;
	logic [31:0]         mag;

	assign mag   = num[31] ? 32'(-num) : 32'(num);
	assign trial = {rem_q, sh_q[DIV_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			sh_q  <= {mag, {FRAC_BITS{1'b0}}};
			neg_q <= num[31];
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			sh_q  <= {sh_q[DIV_BITS-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q) begin
			quo = (sh_q > 48'h0000_8000_0000) ? 32'sh80000000 : 32'(-sh_q);
		end else begin
			quo = (sh_q > 48'h0000_7fff_ffff) ? 32'sh7fffffff : 32'(sh_q);
		end
	end

	assign done = done_q;

	always_ff @(posedge clk) begin
		if (arst_n && start) begin
			assert (den != '0) else $error("divider started with zero divisor");
		end
	end

endmodule

// ----- hdl/etcbf_dp.sv -----
// Datapath: configuration, working registers, shared multiplier, divider and result registers.
module etcbf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [103:0]        in_data,
	input  etcbf_pkg::cmd_t     cmd,
	output etcbf_pkg::sts_t     sts,
	output logic [71:0]         out_data,
	output logic [2:0]          out_user
);
	import etcbf_pkg::*;

	logic signed [31:0] goal_x_q, goal_y_q, obst_x_q, obst_y_q;
	logic [20:0]        safe_r_q, look_q, kp_q, eps_q;
	logic signed [31:0] hs_q, ht_q;

	logic signed [31:0] x_q, y_q;
	logic signed [17:0] c_q, s_q;
	logic signed [31:0] px_q, py_q, dx_q, dy_q, h_q, b_q, g1_q, g2_q, tmp_q;
	logic signed [31:0] gxs_q, gys_q, ex_q, ey_q, pdx_q, pdy_q, vn_q, wn_q;
	logic signed [31:0] diff_q, nd_q, dv_q, dw_q, lam_q, uv_q, uw_q;
	logic signed [67:0] acc_q;
	logic signed [63:0] mul_q;
	logic               near_q, start_q, trig_q, big_q, goal_q, fire_q;
	logic [1:0]         kind_q;

	logic [71:0]        odata_q;
	logic [2:0]         ouser_q;

	logic signed [31:0] op_a, op_b;
	logic signed [47:0] fq;
	logic signed [67:0] fq_w, prod_w, sum_f, dif_f, gx, gy, dvw, dww;
	logic signed [31:0] div_num, quo, eps_s, look_s, held_v, held_w;
	logic [DEN_W-1:0]   div_den, a2_u;
	logic [20:0]        eps_eff;
	logic               div_done, recov;

	assign fq     = mul_q[63:16];
	assign fq_w   = 68'(fq);
	assign prod_w = 68'(mul_q);
	assign sum_f  = acc_q + fq_w;
	assign dif_f  = acc_q - fq_w;
	assign gx     = 68'(x_q) - 68'(goal_x_q);
	assign gy     = 68'(y_q) - 68'(goal_y_q);
	assign dvw    = absw(68'(hs_q) - 68'(vn_q));
	assign dww    = absw(68'(ht_q) - 68'(wn_q));
	assign eps_eff = (eps_q == '0) ? 21'd1 : eps_q;
	assign eps_s  = 32'($signed({1'b0, eps_eff}));
	assign look_s = 32'($signed({1'b0, look_q}));
	assign a2_u   = sum_f[DEN_W-1:0];

	assign recov = !trig_q && (68'(nd_q) < -MARGIN_Q) &&
		(big_q || (acc_q + prod_w > DRIFT_SQ));

	// Operands of the shared multiplier for each step.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.step)
			SQ_00: begin op_a = look_s; op_b = 32'(c_q); end
			SQ_01: begin op_a = look_s; op_b = 32'(s_q); end
			SQ_03: begin op_a = dx_q;   op_b = dx_q; end
			SQ_04: begin op_a = dy_q;   op_b = dy_q; end
			SQ_05: begin op_a = 32'($signed({1'b0, safe_r_q})); op_b = op_a; end
			SQ_06: begin op_a = dx_q;   op_b = 32'(c_q); end
			SQ_07: begin op_a = dy_q;   op_b = 32'(s_q); end
			SQ_08: begin op_a = dy_q;   op_b = 32'(c_q); end
			SQ_09: begin op_a = dx_q;   op_b = 32'(s_q); end
			SQ_11: begin op_a = look_s; op_b = tmp_q; end
			SQ_13: begin op_a = gxs_q;  op_b = gxs_q; end
			SQ_14: begin op_a = gys_q;  op_b = gys_q; end
			SQ_17: begin op_a = 32'($signed({1'b0, kp_q})); op_b = ex_q; end
			SQ_18: begin op_a = 32'($signed({1'b0, kp_q})); op_b = ey_q; end
			SQ_19: begin op_a = 32'(c_q); op_b = pdx_q; end
			SQ_20: begin op_a = 32'(s_q); op_b = pdy_q; end
			SQ_21: begin op_a = 32'(c_q); op_b = pdy_q; end
			SQ_22: begin op_a = 32'(s_q); op_b = pdx_q; end
			SQ_24: begin op_a = g1_q;   op_b = hs_q; end
			SQ_25: begin op_a = g2_q;   op_b = ht_q; end
			SQ_26: begin op_a = g1_q;   op_b = vn_q; end
			SQ_27: begin op_a = g2_q;   op_b = wn_q; end
			SQ_28: begin op_a = hs_q;   op_b = hs_q; end
			SQ_29: begin op_a = ht_q;   op_b = ht_q; end
			SQ_31: begin op_a = dv_q;   op_b = dv_q; end
			SQ_32: begin op_a = dw_q;   op_b = dw_q; end
			SQ_34: begin op_a = g1_q;   op_b = g1_q; end
			SQ_35: begin op_a = g2_q;   op_b = g2_q; end
			SQ_38: begin op_a = lam_q;  op_b = g1_q; end
			SQ_39: begin op_a = lam_q;  op_b = g2_q; end
			default: begin op_a = '0;   op_b = '0; end
		endcase
	end

	// Divider operands: steering quotient, projection multiplier and the two kicks.
	always_comb begin
		div_num = g2_q;
		div_den = DEN_W'(eps_eff);
		unique case (cmd.step)
			SQ_23: begin div_num = sat32(dif_f); div_den = DEN_W'(look_q); end
			SQ_36: begin div_num = nd_q; div_den = a2_u; end
			SQ_41: begin div_num = g1_q; div_den = DEN_W'(eps_eff); end
			default: begin div_num = g2_q; div_den = DEN_W'(eps_eff); end
		endcase
	end

	etcbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= 32'sd196608;
			goal_y_q <= 32'sd0;
			obst_x_q <= 32'sd98304;
			obst_y_q <= -32'sd6554;
			safe_r_q <= 21'd47841;
			look_q   <= 21'd9830;
			kp_q     <= 21'd32768;
			eps_q    <= 21'd655;
			hs_q     <= '0;
			ht_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GOAL_X: goal_x_q <= cfg_data;
					REG_GOAL_Y: goal_y_q <= cfg_data;
					REG_OBST_X: obst_x_q <= cfg_data;
					REG_OBST_Y: obst_y_q <= cfg_data;
					REG_SAFE_R: safe_r_q <= cfg_data[20:0];
					REG_LOOK:   look_q   <= cfg_data[20:0];
					REG_KP:     kp_q     <= cfg_data[20:0];
					REG_EPS:    eps_q    <= cfg_data[20:0];
					default:    eps_q    <= eps_q;
				endcase
			end
			if (cmd.commit) begin
				hs_q <= held_v;
				ht_q <= held_w;
			end
		end
	end

	always_comb begin
		if (goal_q) begin
			held_v = '0;
			held_w = '0;
		end else if (fire_q) begin
			held_v = clampv(uv_q, 32'(MAX_SPEED));
			held_w = clampv(uw_q, 32'(MAX_TURN));
		end else begin
			held_v = hs_q;
			held_w = ht_q;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= 64'(op_a) * 64'(op_b);
		if (cmd.load) begin
			x_q    <= in_data[31:0];
			y_q    <= in_data[63:32];
			c_q    <= in_data[81:64];
			s_q    <= in_data[99:82];
			goal_q <= 1'b0;
			fire_q <= 1'b0;
			kind_q <= KIND_NONE;
		end
		if (cmd.commit) begin
			odata_q <= {6'b0, h_q, held_w[18:0], held_v[14:0]};
			ouser_q <= {kind_q, goal_q};
		end
		if (cmd.run) begin
			unique case (cmd.step)
				SQ_01: px_q <= sat32(68'(x_q) + fq_w);
				SQ_02: begin
					py_q <= sat32(68'(y_q) + fq_w);
					dx_q <= sat32(68'(px_q) - 68'(obst_x_q));
				end
				SQ_03: dy_q <= sat32(68'(py_q) - 68'(obst_y_q));
				SQ_04: acc_q <= fq_w;
				SQ_05: acc_q <= sum_f;
				SQ_06: h_q <= sat32(dif_f);
				SQ_07: acc_q <= fq_w;
				SQ_08: begin
					g1_q <= sat32(sum_f <<< 1);
					b_q  <= sat32(-68'(h_q));
				end
				SQ_09: acc_q <= fq_w;
				SQ_10: tmp_q <= sat32(dif_f);
				SQ_12: begin
					g2_q   <= sat32(fq_w <<< 1);
					gxs_q  <= sat32(gx);
					gys_q  <= sat32(gy);
					near_q <= (absw(gx) < 68'(GOAL_TOL)) && (absw(gy) < 68'(GOAL_TOL));
				end
				SQ_14: acc_q <= prod_w;
				SQ_15: goal_q <= sts.reach;
				SQ_16: begin
					ex_q <= sat32(68'(px_q) - 68'(goal_x_q));
					ey_q <= sat32(68'(py_q) - 68'(goal_y_q));
				end
				SQ_18: pdx_q <= sat32(-fq_w);
				SQ_19: pdy_q <= sat32(-fq_w);
				SQ_20: acc_q <= fq_w;
				SQ_21: vn_q <= sat32(sum_f);
				SQ_22: acc_q <= fq_w;
				SQ_24: wn_q <= quo;
				SQ_25: acc_q <= fq_w;
				SQ_26: diff_q <= sat32(68'(b_q) - sum_f);
				SQ_27: acc_q <= fq_w;
				SQ_28: nd_q <= sat32(68'(b_q) - sum_f);
				SQ_29: acc_q <= prod_w;
				SQ_30: begin
					start_q <= (acc_q + prod_w) < START_SQ;
					trig_q  <= 68'(diff_q) >= 68'(eps_s);
					big_q   <= (dvw > DRIFT_Q) || (dww > DRIFT_Q);
					dv_q    <= sat32(dvw);
					dw_q    <= sat32(dww);
				end
				SQ_32: acc_q <= prod_w;
				SQ_33: begin
					fire_q <= sts.fire;
					uv_q   <= vn_q;
					uw_q   <= wn_q;
					priority if (trig_q) kind_q <= KIND_BARRIER;
					else if (recov)      kind_q <= KIND_RECOV;
					else if (start_q)    kind_q <= KIND_START;
					else                 kind_q <= KIND_NONE;
				end
				SQ_35: acc_q <= fq_w;
				SQ_36: begin
					if (sts.tiny) begin
						uv_q <= '0;
						uw_q <= '0;
					end
				end
				SQ_37: lam_q <= quo;
				SQ_39: uv_q <= sat32(68'(vn_q) + fq_w);
				SQ_40: uw_q <= sat32(68'(wn_q) + fq_w);
				SQ_42: uv_q <= sat32(68'(uv_q) + 68'(quo));
				SQ_43: uw_q <= sat32(68'(uw_q) + 68'(quo));
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_comb begin
		sts.len_zero = (look_q == '0);
		sts.reach    = near_q && ((acc_q + prod_w) < GOAL_TOL2);
		sts.fire     = trig_q || start_q || recov;
		sts.nd_pos   = nd_q > 32'sd0;
		sts.tiny     = sum_f <= TINY_Q;
		sts.trig     = trig_q;
		sts.div_done = div_done;
	end

	assign out_data = odata_q;
	assign out_user = ouser_q;

endmodule

// ----- hdl/etcbf_ctrl.sv -----
// Controller: sequences the datapath steps, waits on the divider and owns the result handshake.
module etcbf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  etcbf_pkg::sts_t     sts,
	output etcbf_pkg::cmd_t     cmd
);
	import etcbf_pkg::*;

	localparam logic [1:0] CS_IDLE = 2'd0;
	localparam logic [1:0] CS_RUN  = 2'd1;
	localparam logic [1:0] CS_DIVW = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              mv_q;
	logic              accept, out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == CS_IDLE);
	assign out_free = !mv_q || m_tready;

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		cmd.run    = (state_q == CS_RUN);
		cmd.step   = step_q;
		cmd.load   = accept;
		cmd.div_go = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				if (accept && !sts.len_zero) begin
					state_d = CS_RUN;
					step_d  = SQ_00;
				end
			end
			CS_RUN: begin
				step_d = step_q + 6'd1;
				priority if (step_q == SQ_15 && sts.reach) begin
					step_d = SQ_44;
				end else if (step_q == SQ_33) begin
					step_d = !sts.fire ? SQ_44 : (sts.nd_pos ? SQ_34 : SQ_41);
				end else if (step_q == SQ_36 && sts.tiny) begin
					step_d = SQ_41;
				end else if (step_q == SQ_41 && !sts.trig) begin
					step_d = SQ_44;
				end else if (step_q == SQ_23 || step_q == SQ_36 ||
						step_q == SQ_41 || step_q == SQ_42) begin
					cmd.div_go = 1'b1;
					state_d    = CS_DIVW;
				end else if (step_q == SQ_44) begin
					step_d = step_q;
					if (out_free) begin
						cmd.commit = 1'b1;
						state_d    = CS_IDLE;
					end
				end else begin
					step_d = step_q + 6'd1;
				end
			end
			CS_DIVW: begin
				if (sts.div_done) begin
					state_d = CS_RUN;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= SQ_00;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.commit) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = mv_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_RUN) |-> (step_q <= SQ_44))
		else $error("sequencer step beyond the last step");

	a_div_return: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_DIVW) |=> (state_q == CS_DIVW || state_q == CS_RUN))
		else $error("divider wait left to an unexpected state");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_go_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> (state_q == CS_RUN))
		else $error("divider started outside the run state");

endmodule

// ----- hdl/event_triggered_cbf_unicycle_control_core.sv -----
// Top level of the event-triggered barrier safety filter for a unicycle robot.
//
// Channel   Direction  Group                  Contents
// s_        in         tvalid/tready/tdata    pose and heading, one transfer per tick
// m_        out        tvalid/tready/tdata/   held command and barrier value
//                      tuser
// cfg_      in         we/index/data          goal, obstacle, radius, look-ahead, gain, epsilon
//
// A tick walks up to 45 sequencer steps around a shared 32x32 multiplier, and each
// 48-bit division holds the sequencer until the divider is done. A tick at the goal
// runs no division, one that does not fire only the steering division, and one with
// all corrections all four divisions.
// A zero look-ahead consumes the transfer and gives no result.
// arst_n clears the sequencer, the held command and the configuration to defaults.
// A new pose is taken once the previous result is registered, even while it waits.
module event_triggered_cbf_unicycle_control_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // pos_x, pos_y, cos_heading, sin_heading, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // lin_vel, ang_vel, barrier_value, zero pad
	output logic [2:0]   m_tuser,   // goal_reached, trigger_kind
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import etcbf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	etcbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	etcbf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
